### hw/rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg: shared types for the selective-repeat sender window
// Command and result codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned WIN_CFG_W  = 6;
  localparam int unsigned OUT_SLOT_W = 5;
  localparam int unsigned RES_CAP    = 32;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DIV_CNT_W  = 5;

  localparam logic [WIN_CFG_W-1:0] WIN_RESET = 6'd8;

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_GRANT  = 2'd0,
    KIND_REFUSE = 2'd1,
    KIND_ACK    = 2'd2,
    KIND_RETX   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLIDE,
    ST_ACK_OUT,
    ST_SCAN,
    ST_DIV,
    ST_DIV_FIN
  } state_e;

  typedef struct packed {
    logic  latch_in;
    logic  send_grant;
    logic  ack_eval;
    logic  slide_step;
    logic  scan_init;
    logic  scan_skip;
    logic  scan_take;
    logic  out_load;
    kind_e out_kind;
    logic  out_last;
    logic  div_step;
    logic  div_finish;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic send_ok;
    logic ack_at_base;
    logic slide_more;
    logic scan_done;
    logic scan_marked;
    logic pend_valid;
    logic out_free;
    logic div_last;
  } dp_stat_t;

endpackage

### hw/rtl/selective_repeat_sender_window_top.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_top: selective-repeat sender window control
// Grants or refuses send requests, marks and absorbs acknowledgements and
// walks the window for retransmits on a timeout.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   command_i, ack_seq_i
//   out      source     out_valid_o / out_stall_i kind_o, seq_o, slot_o,
//                                                  window_base_o, last_o
//   cfg      sink       cfg_we_i                  cfg_wdata_i (window size)
//
// One item at a time: a send is granted or refused in decode, an ack inside the
// window is marked or, when it meets the base, slides the base over the marked
// slots that follow, and a timeout walks the outstanding sequences for retransmits.
// A window size write stalls the input while the slot remainders are worked
// out one bit a cycle.
// Reset restores base and next to zero, window size 8 and clears all marks.
// A finished result waits in the output register; the next item is taken
// meanwhile and holds in the controller only when it needs that register.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_top #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic [srsw_pkg::SEQ_W-1:0]       ack_seq_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       kind_o,
  output logic [srsw_pkg::SEQ_W-1:0]       seq_o,
  output logic [srsw_pkg::OUT_SLOT_W-1:0]  slot_o,
  output logic [srsw_pkg::SEQ_W-1:0]       window_base_o,
  output logic                             last_o,
  input  logic                             cfg_we_i,
  input  logic [srsw_pkg::WIN_CFG_W-1:0]   cfg_wdata_i
);

  srsw_pkg::dp_cmd_t  dp_cmd;
  srsw_pkg::dp_stat_t dp_stat;

  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we_i),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  srsw_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .command_i     (command_i),
    .ack_seq_i     (ack_seq_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .seq_o         (seq_o),
    .slot_o        (slot_o),
    .window_base_o (window_base_o),
    .last_o        (last_o)
  );

endmodule

### hw/rtl/srsw_dp.sv
// ----------------------------------------------------------------------------
// srsw_dp: sender window datapath
// Sequence and slot counters, acknowledgement marks, retransmit walk,
// slot remainder unit for window changes and the result register.
// ----------------------------------------------------------------------------
module srsw_dp #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  srsw_pkg::dp_cmd_t                  cmd_i,
  output srsw_pkg::dp_stat_t                 stat_o,
  input  logic [1:0]                         command_i,
  input  logic [srsw_pkg::SEQ_W-1:0]         ack_seq_i,
  input  logic                               cfg_we_i,
  input  logic [srsw_pkg::WIN_CFG_W-1:0]     cfg_wdata_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [1:0]                         kind_o,
  output logic [srsw_pkg::SEQ_W-1:0]         seq_o,
  output logic [srsw_pkg::OUT_SLOT_W-1:0]    slot_o,
  output logic [srsw_pkg::SEQ_W-1:0]         window_base_o,
  output logic                               last_o
);

  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W  = SLOT_W + 1;
  localparam int unsigned W_W    = $clog2(MAX_WINDOW + 1);

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [SUM_W-1:0]  k,
                                                 input logic [SUM_W-1:0]  w);
    logic [SUM_W-1:0] r;
    r = SUM_W'(s) + k;
    if (r >= w) begin
      r = r - w;
    end
    return r[SLOT_W-1:0];
  endfunction

  // control state
  logic [srsw_pkg::WIN_CFG_W-1:0] window_size_q, window_size_d;
  logic [31:0]                    base_seq_q, base_seq_d;
  logic [31:0]                    next_seq_q, next_seq_d;
  logic [SLOT_W-1:0]              base_slot_q, base_slot_d;
  logic [SLOT_W-1:0]              next_slot_q, next_slot_d;
  logic [MAX_WINDOW-1:0]          marks_q, marks_d;
  srsw_pkg::cmd_e                 cmd_q, cmd_d;
  logic                           pend_v_q, pend_v_d;
  logic                           out_valid_q, out_valid_d;

  // working registers
  logic [31:0]                    ack_q, ack_d;
  logic [SLOT_W-1:0]              ack_slot_q, ack_slot_d;
  logic [W_W-1:0]                 walk_q, walk_d;
  logic [SLOT_W-1:0]              scan_slot_q, scan_slot_d;
  logic [srsw_pkg::CNT_W-1:0]     scan_cnt_q, scan_cnt_d;
  logic [31:0]                    pend_seq_q, pend_seq_d;
  logic [SLOT_W-1:0]              pend_slot_q, pend_slot_d;
  logic [31:0]                    div_a_q, div_a_d;
  logic [31:0]                    div_b_q, div_b_d;
  logic [SLOT_W-1:0]              rem_a_q, rem_a_d;
  logic [SLOT_W-1:0]              rem_b_q, rem_b_d;
  logic [srsw_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  srsw_pkg::kind_e                out_kind_q, out_kind_d;
  logic [31:0]                    out_seq_q, out_seq_d;
  logic [srsw_pkg::OUT_SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [31:0]                    out_base_q, out_base_d;
  logic                           out_last_q, out_last_d;

  // window and derived values
  logic [6:0]        ws_ext, max_ext, win_full;
  logic [W_W-1:0]    win;
  logic [SUM_W-1:0]  win_sum;
  logic [31:0]       win_ext;
  logic [31:0]       outstanding;
  logic [31:0]       ack_off;
  logic              ack_in_win, ack_at_base;
  logic [SLOT_W-1:0] ack_win_slot, base_slot_inc, next_slot_inc, scan_slot_inc;
  logic [SUM_W-1:0]  rem_a_sh, rem_b_sh;
  logic              out_free;

  assign ws_ext   = {1'b0, window_size_q};
  assign max_ext  = 7'(MAX_WINDOW);
  assign win_full = (ws_ext == 7'd0) ? 7'd1 : ((ws_ext > max_ext) ? max_ext : ws_ext);
  assign win      = W_W'(win_full);
  assign win_sum  = SUM_W'(win);
  assign win_ext  = 32'(win);

  assign outstanding = next_seq_q - base_seq_q;
  assign ack_off     = ack_q - base_seq_q;
  assign ack_in_win  = (ack_off != 32'd0) && (ack_off < outstanding) && (ack_off < win_ext);
  assign ack_at_base = (ack_off == 32'd0) && (outstanding != 32'd0);

  assign ack_win_slot  = slot_add(base_slot_q, SUM_W'(ack_off), win_sum);
  assign base_slot_inc = slot_add(base_slot_q, SUM_W'(1), win_sum);
  assign next_slot_inc = slot_add(next_slot_q, SUM_W'(1), win_sum);
  assign scan_slot_inc = slot_add(scan_slot_q, SUM_W'(1), win_sum);

  // one restoring step per cycle for base mod W and outstanding mod W
  assign rem_a_sh = {rem_a_q, div_a_q[31]};
  assign rem_b_sh = {rem_b_q, div_b_q[31]};

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.send_ok     = outstanding < win_ext;
    stat_o.ack_at_base = ack_at_base;
    stat_o.slide_more  = (walk_q < win) && (base_seq_q != next_seq_q) && marks_q[base_slot_q];
    stat_o.scan_done   = (32'(walk_q) == outstanding) ||
                         (scan_cnt_q == srsw_pkg::CNT_W'(srsw_pkg::RES_CAP));
    stat_o.scan_marked = marks_q[scan_slot_q];
    stat_o.pend_valid  = pend_v_q;
    stat_o.out_free    = out_free;
    stat_o.div_last    = div_cnt_q == srsw_pkg::DIV_CNT_W'(srsw_pkg::DIV_STEPS - 1);
  end

  always_comb begin
    window_size_d = window_size_q;
    base_seq_d    = base_seq_q;
    next_seq_d    = next_seq_q;
    base_slot_d   = base_slot_q;
    next_slot_d   = next_slot_q;
    marks_d       = marks_q;
    cmd_d         = cmd_q;
    pend_v_d      = pend_v_q;
    ack_d         = ack_q;
    ack_slot_d    = ack_slot_q;
    walk_d        = walk_q;
    scan_slot_d   = scan_slot_q;
    scan_cnt_d    = scan_cnt_q;
    pend_seq_d    = pend_seq_q;
    pend_slot_d   = pend_slot_q;
    div_a_d       = div_a_q;
    div_b_d       = div_b_q;
    rem_a_d       = rem_a_q;
    rem_b_d       = rem_b_q;
    div_cnt_d     = div_cnt_q;

    if (cmd_i.latch_in) begin
      cmd_d = srsw_pkg::cmd_e'(command_i);
      ack_d = ack_seq_i;
    end

    if (cmd_i.send_grant) begin
      marks_d[next_slot_q] = 1'b0;
      next_seq_d           = next_seq_q + 32'd1;
      next_slot_d          = next_slot_inc;
    end

    if (cmd_i.ack_eval) begin
      if (ack_in_win) begin
        marks_d[ack_win_slot] = 1'b1;
        ack_slot_d            = ack_win_slot;
      end else if (ack_at_base) begin
        ack_slot_d  = base_slot_q;
        base_seq_d  = base_seq_q + 32'd1;
        base_slot_d = base_slot_inc;
        walk_d      = W_W'(1);
      end else begin
        ack_slot_d = '0;
      end
    end

    // slide base over a marked slot and drop its mark
    if (cmd_i.slide_step) begin
      marks_d[base_slot_q] = 1'b0;
      base_seq_d           = base_seq_q + 32'd1;
      base_slot_d          = base_slot_inc;
      walk_d               = walk_q + W_W'(1);
    end

    if (cmd_i.scan_init) begin
      walk_d      = '0;
      scan_slot_d = base_slot_q;
      scan_cnt_d  = '0;
      pend_v_d    = 1'b0;
    end

    if (cmd_i.scan_skip || cmd_i.scan_take) begin
      walk_d      = walk_q + W_W'(1);
      scan_slot_d = scan_slot_inc;
    end

    // hold the newest retransmit back until the walk shows whether it is the last
    if (cmd_i.scan_take) begin
      pend_v_d    = 1'b1;
      pend_seq_d  = base_seq_q + 32'(walk_q);
      pend_slot_d = scan_slot_q;
      scan_cnt_d  = scan_cnt_q + srsw_pkg::CNT_W'(1);
    end

    if (cmd_i.div_step) begin
      rem_a_d   = (rem_a_sh >= win_sum) ? SLOT_W'(rem_a_sh - win_sum) : SLOT_W'(rem_a_sh);
      rem_b_d   = (rem_b_sh >= win_sum) ? SLOT_W'(rem_b_sh - win_sum) : SLOT_W'(rem_b_sh);
      div_a_d   = {div_a_q[30:0], 1'b0};
      div_b_d   = {div_b_q[30:0], 1'b0};
      div_cnt_d = div_cnt_q + srsw_pkg::DIV_CNT_W'(1);
    end

    if (cmd_i.div_finish) begin
      base_slot_d = rem_a_q;
      next_slot_d = slot_add(rem_a_q, SUM_W'(rem_b_q), win_sum);
    end

    // a new window drops every mark and restarts the slot remainders
    if (cfg_we_i) begin
      window_size_d = cfg_wdata_i;
      marks_d       = '0;
      div_a_d       = base_seq_q;
      div_b_d       = outstanding;
      rem_a_d       = '0;
      rem_b_d       = '0;
      div_cnt_d     = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_seq_d   = out_seq_q;
    out_slot_d  = out_slot_q;
    out_base_d  = out_base_q;
    out_last_d  = out_last_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_kind_d  = cmd_i.out_kind;
      out_base_d  = base_seq_q;
      out_last_d  = cmd_i.out_last;
      case (cmd_i.out_kind)
        srsw_pkg::KIND_GRANT, srsw_pkg::KIND_REFUSE: begin
          out_seq_d  = next_seq_q;
          out_slot_d = srsw_pkg::OUT_SLOT_W'(next_slot_q);
        end
        srsw_pkg::KIND_ACK: begin
          out_seq_d  = ack_q;
          out_slot_d = srsw_pkg::OUT_SLOT_W'(ack_slot_q);
        end
        srsw_pkg::KIND_RETX: begin
          out_seq_d  = pend_seq_q;
          out_slot_d = srsw_pkg::OUT_SLOT_W'(pend_slot_q);
        end
        default: begin
          out_seq_d  = next_seq_q;
          out_slot_d = srsw_pkg::OUT_SLOT_W'(next_slot_q);
        end
      endcase
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= srsw_pkg::WIN_RESET;
      base_seq_q    <= '0;
      next_seq_q    <= '0;
      base_slot_q   <= '0;
      next_slot_q   <= '0;
      marks_q       <= '0;
      cmd_q         <= srsw_pkg::CMD_NOP;
      pend_v_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      window_size_q <= window_size_d;
      base_seq_q    <= base_seq_d;
      next_seq_q    <= next_seq_d;
      base_slot_q   <= base_slot_d;
      next_slot_q   <= next_slot_d;
      marks_q       <= marks_d;
      cmd_q         <= cmd_d;
      pend_v_q      <= pend_v_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ack_q       <= ack_d;
    ack_slot_q  <= ack_slot_d;
    walk_q      <= walk_d;
    scan_slot_q <= scan_slot_d;
    scan_cnt_q  <= scan_cnt_d;
    pend_seq_q  <= pend_seq_d;
    pend_slot_q <= pend_slot_d;
    div_a_q     <= div_a_d;
    div_b_q     <= div_b_d;
    rem_a_q     <= rem_a_d;
    rem_b_q     <= rem_b_d;
    div_cnt_q   <= div_cnt_d;
    out_kind_q  <= out_kind_d;
    out_seq_q   <= out_seq_d;
    out_slot_q  <= out_slot_d;
    out_base_q  <= out_base_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign seq_o         = out_seq_q;
  assign slot_o        = out_slot_q;
  assign window_base_o = out_base_q;
  assign last_o        = out_last_q;

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result register overwritten while its item is stalled");

  a_outstanding_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_seq_q - base_seq_q) <= 32'(MAX_WINDOW))
    else $error("more sequences outstanding than the largest window");

  a_base_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(base_seq_q) |-> base_seq_q == $past(base_seq_q) + 32'd1)
    else $error("window base moved by more than one per cycle");

  a_retx_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_take |-> scan_cnt_q < srsw_pkg::CNT_W'(srsw_pkg::RES_CAP))
    else $error("retransmit walk took more than the result cap");
`endif

endmodule

### hw/rtl/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl: sender window controller
// Sequences each command through decode, base sliding, retransmit walk and
// the slot remainder steps after a window change.
// ----------------------------------------------------------------------------
module srsw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cfg_we_i,
  input  srsw_pkg::dp_stat_t  stat_i,
  output srsw_pkg::dp_cmd_t   cmd_o
);

  srsw_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      srsw_pkg::ST_IDLE: begin
        if (cfg_we_i) begin
          state_d = srsw_pkg::ST_DIV;
        end else if (in_valid_i) begin
          state_d = srsw_pkg::ST_DECODE;
        end
      end
      srsw_pkg::ST_DECODE: begin
        case (stat_i.cmd)
          srsw_pkg::CMD_SEND: begin
            if (stat_i.out_free) begin
              state_d = srsw_pkg::ST_IDLE;
            end
          end
          srsw_pkg::CMD_ACK: begin
            state_d = stat_i.ack_at_base ? srsw_pkg::ST_SLIDE : srsw_pkg::ST_ACK_OUT;
          end
          srsw_pkg::CMD_TIMEOUT: state_d = srsw_pkg::ST_SCAN;
          default:               state_d = srsw_pkg::ST_IDLE;
        endcase
      end
      srsw_pkg::ST_SLIDE: begin
        if (!stat_i.slide_more) begin
          state_d = srsw_pkg::ST_ACK_OUT;
        end
      end
      srsw_pkg::ST_ACK_OUT: begin
        if (stat_i.out_free) begin
          state_d = srsw_pkg::ST_IDLE;
        end
      end
      srsw_pkg::ST_SCAN: begin
        if (stat_i.scan_done && (!stat_i.pend_valid || stat_i.out_free)) begin
          state_d = srsw_pkg::ST_IDLE;
        end
      end
      srsw_pkg::ST_DIV: begin
        if (cfg_we_i) begin
          state_d = srsw_pkg::ST_DIV;
        end else if (stat_i.div_last) begin
          state_d = srsw_pkg::ST_DIV_FIN;
        end
      end
      srsw_pkg::ST_DIV_FIN: begin
        state_d = cfg_we_i ? srsw_pkg::ST_DIV : srsw_pkg::ST_IDLE;
      end
      default: state_d = srsw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = srsw_pkg::KIND_GRANT;
    in_stall_o     = (state_q != srsw_pkg::ST_IDLE) || cfg_we_i;
    case (state_q)
      srsw_pkg::ST_IDLE: begin
        cmd_o.latch_in = in_valid_i && !cfg_we_i;
      end
      srsw_pkg::ST_DECODE: begin
        case (stat_i.cmd)
          srsw_pkg::CMD_SEND: begin
            if (stat_i.out_free) begin
              cmd_o.send_grant = stat_i.send_ok;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.out_kind   = stat_i.send_ok ? srsw_pkg::KIND_GRANT
                                                : srsw_pkg::KIND_REFUSE;
            end
          end
          srsw_pkg::CMD_ACK:     cmd_o.ack_eval  = 1'b1;
          srsw_pkg::CMD_TIMEOUT: cmd_o.scan_init = 1'b1;
          default: ;
        endcase
      end
      srsw_pkg::ST_SLIDE: begin
        cmd_o.slide_step = stat_i.slide_more;
      end
      srsw_pkg::ST_ACK_OUT: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_last = 1'b1;
        cmd_o.out_kind = srsw_pkg::KIND_ACK;
      end
      srsw_pkg::ST_SCAN: begin
        cmd_o.out_kind = srsw_pkg::KIND_RETX;
        if (stat_i.scan_done) begin
          // flush the held retransmit as the final result
          cmd_o.out_load = stat_i.pend_valid && stat_i.out_free;
          cmd_o.out_last = 1'b1;
        end else if (stat_i.scan_marked) begin
          cmd_o.scan_skip = 1'b1;
        end else if (!stat_i.pend_valid) begin
          cmd_o.scan_take = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.scan_take = 1'b1;
          cmd_o.out_load  = 1'b1;
        end
      end
      srsw_pkg::ST_DIV: begin
        cmd_o.div_step = !cfg_we_i;
      end
      srsw_pkg::ST_DIV_FIN: begin
        cmd_o.div_finish = !cfg_we_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srsw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch_in |=> state_q == srsw_pkg::ST_DECODE)
    else $error("accepted item did not enter decode");

  a_div_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srsw_pkg::ST_DIV_FIN) |-> $past(state_q) == srsw_pkg::ST_DIV)
    else $error("slot remainder finished without its steps");

  a_no_load_in_slide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.slide_step |-> !cmd_o.out_load && !in_stall_o == 1'b0)
    else $error("result loaded while the base is still sliding");
`endif

endmodule
